[rtl/apss_pkg.sv]
// Shared types, constants and helpers for the access point score select block.
// Used by apss_div, apss_sqrt and access_point_score_select.
package apss_pkg;

    localparam int NUM_APS   = 32;
    localparam int AP_IW     = 5;
    localparam int CNT_W     = 6;
    localparam int DVD_W     = 48;
    localparam int DVS_W     = 41;
    localparam int RSUM_W    = 40;
    localparam int TOT_W     = 27;
    localparam logic [7:0]  MAX_RATES = 8'd255;
    localparam logic [16:0] SCORE_ONE = 17'h10000;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RATE = 2'd1,
        OP_SEL  = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    localparam logic [2:0] CFG_DIST  = 3'd0;
    localparam logic [2:0] CFG_WT    = 3'd1;
    localparam logic [2:0] CFG_WD    = 3'd2;
    localparam logic [2:0] CFG_WC    = 3'd3;
    localparam logic [2:0] CFG_WU    = 3'd4;
    localparam logic [2:0] CFG_APCNT = 3'd5;

    // link rate in Mbps Q8.4 from squared distance in Q.8 m^2
    function automatic logic [11:0] link_rate(input logic [32:0] d2);
        logic [11:0] r;
        if (d2 < 33'd6400)        r = 12'd2400;
        else if (d2 < 33'd25600)  r = 12'd2080;
        else if (d2 < 33'd57600)  r = 12'd1600;
        else if (d2 < 33'd102400) r = 12'd1040;
        else if (d2 < 33'd160000) r = 12'd480;
        else                      r = 12'd104;
        return r;
    endfunction

endpackage

[rtl/apss_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on apss_pkg for operand widths.
module apss_div
    import apss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/apss_sqrt.sv]
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on apss_pkg only for the shared counter width.
module apss_sqrt
    import apss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_radicand,
    output logic        o_done,
    output logic [15:0] o_root
);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rad;
    logic [16:0]      r_rem;
    logic [15:0]      r_root;
    logic [18:0]      rem_sh, trial;
    logic             ge;

    assign rem_sh = {r_rem, r_rad[31:30]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(15)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[29:0], 2'b00};
            r_rem  <= ge ? 17'(rem_sh - trial) : 17'(rem_sh);
            r_root <= {r_root[14:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[rtl/access_point_score_select.sv]
// Access point scoring and selection: table of 32 entries, one select over a small sequencer.
// Depends on apss_pkg, apss_div and apss_sqrt.
//
// Load and no-operation requests leave the sequencer idle. An add-rate request waits for
// its reciprocal division. A select request walks the ap_count entries once, and a second
// time if the first pass found a candidate. In the first pass a candidate needs squared
// distance, a 16-step square root and up to two 48-step divisions. In the second pass it
// needs up to three 48-step divisions and four weighted products. All divisions share one
// bit-serial divider. No request is taken while one is in progress. A result that is still
// stalled holds the next select in its final step.
module access_point_score_select
    import apss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [4:0]  i_ap_index,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [7:0]  i_connected_users,
    input  logic [8:0]  i_channel_load,
    input  logic [15:0] i_user_rate,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_selected_ap,
    output logic        o_found,
    output logic [15:0] o_best_score,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [21:0] {
        S_IDLE  = 22'h000001,
        S_ADDW  = 22'h000002,
        S_THR   = 22'h000004,
        S_D2    = 22'h000008,
        S_D2B   = 22'h000010,
        S_CMP   = 22'h000020,
        S_SQRT  = 22'h000040,
        S_RECIP = 22'h000080,
        S_TPUT  = 22'h000100,
        S_UPD   = 22'h000200,
        S_P2    = 22'h000400,
        S_STW   = 22'h000800,
        S_SD    = 22'h001000,
        S_SDW   = 22'h002000,
        S_SU    = 22'h004000,
        S_SUW   = 22'h008000,
        S_SC    = 22'h010000,
        S_M1    = 22'h020000,
        S_M2    = 22'h040000,
        S_M3    = 22'h080000,
        S_BEST  = 22'h100000,
        S_FIN   = 22'h200000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_thr;
    logic [7:0]  r_wt, r_wd, r_wc, r_wu;
    logic [5:0]  r_apc;

    logic [15:0]       r_ex    [NUM_APS];
    logic [15:0]       r_ey    [NUM_APS];
    logic [7:0]        r_eu    [NUM_APS];
    logic [8:0]        r_el    [NUM_APS];
    logic [7:0]        r_rcnt  [NUM_APS];
    logic [RSUM_W-1:0] r_rsum  [NUM_APS];
    logic              r_cand  [NUM_APS];
    logic [15:0]       r_tput  [NUM_APS];
    logic [15:0]       r_dist  [NUM_APS];

    logic [AP_IW-1:0] r_idx, n_idx;
    logic [15:0] r_px, n_px, r_py, n_py;
    logic [5:0]  r_i, n_i, r_n, n_n;
    logic [31:0] r_thr2, n_thr2;
    logic [32:0] r_d2, n_d2;
    logic [11:0] r_lrate, n_lrate;
    logic [15:0] r_cur_t, n_cur_t, r_cur_d, n_cur_d;
    logic        r_found, n_found, r_have, n_have;
    logic [15:0] r_tmax, n_tmax, r_tmin, n_tmin, r_dmax, n_dmax, r_dmin, n_dmin;
    logic [7:0]  r_umax, n_umax;
    logic [16:0] r_st, n_st, r_sd, n_sd, r_su, n_su, r_sc, n_sc;
    logic [TOT_W-1:0] r_total, n_total, r_best_tot, n_best_tot;
    logic [AP_IW-1:0] r_best, n_best;
    logic        r_ov, n_ov, r_ofound, n_ofound;
    logic [4:0]  r_osel, n_osel;
    logic [15:0] r_oscore, n_oscore;

    logic accept;
    logic [AP_IW-1:0] rd;
    logic [15:0] e_x, e_y, dx, dy;
    logic [16:0] mul_a, mul_b;
    logic [33:0] mul_p;
    logic        div_start, div_done, sq_start, sq_done;
    logic [DVD_W-1:0] div_dvd, div_q;
    logic [DVS_W-1:0] div_dvs;
    logic [15:0] sq_root;
    logic [DVS_W-1:0] rsum_add;
    logic        w_load, w_rate, w_p1;
    logic [RSUM_W-1:0] rsum_new;
    logic [8:0]  load_c;

    assign accept      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign rd  = (r_state == S_ADDW) ? r_idx : r_i[AP_IW-1:0];
    assign e_x = r_ex[rd];
    assign e_y = r_ey[rd];
    assign dx  = (r_px >= e_x) ? r_px - e_x : e_x - r_px;
    assign dy  = (r_py >= e_y) ? r_py - e_y : e_y - r_py;
    assign mul_p = mul_a * mul_b;
    assign rsum_add = {1'b0, r_rsum[rd]} + DVS_W'(div_q[32:0]);
    assign rsum_new = rsum_add[RSUM_W] ? {RSUM_W{1'b1}} : rsum_add[RSUM_W-1:0];
    assign load_c   = (r_el[rd] > 9'd256) ? 9'd256 : r_el[rd];

    apss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    apss_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_d2[31:0]),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_comb begin
        case (r_state)
            S_THR:   begin mul_a = {1'b0, r_thr}; mul_b = {1'b0, r_thr}; end
            S_D2:    begin mul_a = {1'b0, dx};    mul_b = {1'b0, dx};    end
            S_D2B:   begin mul_a = {1'b0, dy};    mul_b = {1'b0, dy};    end
            S_SC:    begin mul_a = {9'd0, r_wt};  mul_b = r_st;          end
            S_M1:    begin mul_a = {9'd0, r_wd};  mul_b = r_sd;          end
            S_M2:    begin mul_a = {9'd0, r_wc};  mul_b = r_sc;          end
            S_M3:    begin mul_a = {9'd0, r_wu};  mul_b = r_su;          end
            default: begin mul_a = '0;            mul_b = '0;            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx = r_idx; n_px = r_px; n_py = r_py; n_i = r_i; n_n = r_n;
        n_thr2 = r_thr2; n_d2 = r_d2; n_lrate = r_lrate;
        n_cur_t = r_cur_t; n_cur_d = r_cur_d; n_found = r_found; n_have = r_have;
        n_tmax = r_tmax; n_tmin = r_tmin; n_dmax = r_dmax; n_dmin = r_dmin;
        n_umax = r_umax;
        n_st = r_st; n_sd = r_sd; n_su = r_su; n_sc = r_sc;
        n_total = r_total; n_best_tot = r_best_tot; n_best = r_best;
        n_ov = r_ov && i_stall;
        n_ofound = r_ofound; n_osel = r_osel; n_oscore = r_oscore;
        div_start = 1'b0; div_dvd = '0; div_dvs = '0; sq_start = 1'b0;
        w_load = 1'b0; w_rate = 1'b0; w_p1 = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = i_ap_index;
                    n_px  = i_pos_x;
                    n_py  = i_pos_y;
                    case (t_opcode'(i_opcode))
                        OP_LOAD: w_load = 1'b1;
                        OP_RATE: begin
                            if (r_rcnt[i_ap_index] < MAX_RATES) begin
                                div_start = 1'b1;
                                div_dvd   = DVD_W'(64'h1_0000_0000);
                                div_dvs   = (i_user_rate == 16'd0) ? DVS_W'(1)
                                                                   : DVS_W'(i_user_rate);
                                n_state   = S_ADDW;
                            end
                        end
                        OP_SEL: begin
                            n_i     = '0;
                            n_n     = (r_apc > 6'(NUM_APS)) ? 6'(NUM_APS) : r_apc;
                            n_found = 1'b0;
                            n_have  = 1'b0;
                            n_state = S_THR;
                        end
                        default: ;
                    endcase
                end
            end
            S_ADDW: begin
                if (div_done) begin
                    w_rate  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_THR: begin
                n_thr2  = mul_p[31:0];
                n_state = S_D2;
            end
            S_D2: begin
                if (r_i >= r_n) begin
                    n_i     = '0;
                    n_state = r_found ? S_P2 : S_FIN;
                end else begin
                    n_d2    = {1'b0, mul_p[31:0]};
                    n_state = S_D2B;
                end
            end
            S_D2B: begin
                n_d2    = r_d2 + {1'b0, mul_p[31:0]};
                n_state = S_CMP;
            end
            S_CMP: begin
                w_p1 = 1'b1;
                if (r_d2 <= {1'b0, r_thr2}) begin
                    sq_start = 1'b1;
                    n_lrate  = link_rate(r_d2);
                    n_state  = S_SQRT;
                end else begin
                    n_i     = r_i + 6'd1;
                    n_state = S_D2;
                end
            end
            S_SQRT: begin
                if (sq_done) begin
                    n_cur_d = sq_root;
                    if (r_rcnt[rd] == 8'd0) begin
                        n_cur_t = {4'd0, r_lrate};
                        n_state = S_UPD;
                    end else begin
                        div_start = 1'b1;
                        div_dvd   = DVD_W'(64'h1_0000_0000);
                        div_dvs   = DVS_W'(r_lrate);
                        n_state   = S_RECIP;
                    end
                end
            end
            S_RECIP: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_dvd   = {DVD_W'({1'b0, r_rcnt[rd]} + 9'd1)} << 32;
                    div_dvs   = rsum_add;
                    n_state   = S_TPUT;
                end
            end
            S_TPUT: begin
                if (div_done) begin
                    n_cur_t = (div_q[DVD_W-1:16] != '0) ? 16'hFFFF : div_q[15:0];
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                w_p1 = 1'b1;
                if (!r_found) begin
                    n_tmax = r_cur_t; n_tmin = r_cur_t;
                    n_dmax = r_cur_d; n_dmin = r_cur_d;
                    n_umax = r_eu[rd];
                    n_found = 1'b1;
                end else begin
                    if (r_cur_t > r_tmax) n_tmax = r_cur_t;
                    if (r_cur_t < r_tmin) n_tmin = r_cur_t;
                    if (r_cur_d > r_dmax) n_dmax = r_cur_d;
                    if (r_cur_d < r_dmin) n_dmin = r_cur_d;
                    if (r_eu[rd] > r_umax) n_umax = r_eu[rd];
                end
                n_i     = r_i + 6'd1;
                n_state = S_D2;
            end
            S_P2: begin
                if (r_i >= r_n) begin
                    n_state = S_FIN;
                end else if (!r_cand[rd]) begin
                    n_i = r_i + 6'd1;
                end else if (r_tmax == r_tmin) begin
                    n_st    = SCORE_ONE;
                    n_state = S_SD;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'({r_tput[rd] - r_tmin, 16'd0});
                    div_dvs   = DVS_W'(r_tmax - r_tmin);
                    n_state   = S_STW;
                end
            end
            S_STW: begin
                if (div_done) begin
                    n_st    = div_q[16:0];
                    n_state = S_SD;
                end
            end
            S_SD: begin
                if (r_dmax == r_dmin) begin
                    n_sd    = SCORE_ONE;
                    n_state = S_SU;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'({r_dist[rd] - r_dmin, 16'd0});
                    div_dvs   = DVS_W'(r_dmax - r_dmin);
                    n_state   = S_SDW;
                end
            end
            S_SDW: begin
                if (div_done) begin
                    n_sd    = SCORE_ONE - div_q[16:0];
                    n_state = S_SU;
                end
            end
            S_SU: begin
                if (r_umax == 8'd0) begin
                    n_su    = SCORE_ONE;
                    n_state = S_SC;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'({r_eu[rd], 16'd0});
                    div_dvs   = DVS_W'(r_umax);
                    n_state   = S_SUW;
                end
            end
            S_SUW: begin
                if (div_done) begin
                    n_su    = SCORE_ONE - div_q[16:0];
                    n_state = S_SC;
                end
            end
            S_SC: begin
                n_sc    = {9'd256 - load_c, 8'd0};
                n_total = TOT_W'(mul_p);
                n_state = S_M1;
            end
            S_M1: begin
                n_total = r_total + TOT_W'(mul_p);
                n_state = S_M2;
            end
            S_M2: begin
                n_total = r_total + TOT_W'(mul_p);
                n_state = S_M3;
            end
            S_M3: begin
                n_total = r_total + TOT_W'(mul_p);
                n_state = S_BEST;
            end
            S_BEST: begin
                if (!r_have || r_total > r_best_tot) begin
                    n_best_tot = r_total;
                    n_best     = rd;
                    n_have     = 1'b1;
                end
                n_i     = r_i + 6'd1;
                n_state = S_P2;
            end
            S_FIN: begin
                if (!r_ov || !i_stall) begin
                    n_ov     = 1'b1;
                    n_ofound = r_found;
                    n_osel   = r_found ? r_best : '0;
                    if (!r_found)
                        n_oscore = '0;
                    else if (r_best_tot[TOT_W-1:24] != '0)
                        n_oscore = 16'hFFFF;
                    else
                        n_oscore = r_best_tot[23:8];
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_thr   <= 16'd240;
            r_wt    <= 8'd102;
            r_wd    <= 8'd77;
            r_wc    <= 8'd51;
            r_wu    <= 8'd26;
            r_apc   <= 6'd5;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DIST:  r_thr <= i_cfg_data;
                    CFG_WT:    r_wt  <= i_cfg_data[7:0];
                    CFG_WD:    r_wd  <= i_cfg_data[7:0];
                    CFG_WC:    r_wc  <= i_cfg_data[7:0];
                    CFG_WU:    r_wu  <= i_cfg_data[7:0];
                    CFG_APCNT: r_apc <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_px <= n_px; r_py <= n_py; r_i <= n_i; r_n <= n_n;
        r_thr2 <= n_thr2; r_d2 <= n_d2; r_lrate <= n_lrate;
        r_cur_t <= n_cur_t; r_cur_d <= n_cur_d; r_found <= n_found; r_have <= n_have;
        r_tmax <= n_tmax; r_tmin <= n_tmin; r_dmax <= n_dmax; r_dmin <= n_dmin;
        r_umax <= n_umax;
        r_st <= n_st; r_sd <= n_sd; r_su <= n_su; r_sc <= n_sc;
        r_total <= n_total; r_best_tot <= n_best_tot; r_best <= n_best;
        r_ofound <= n_ofound; r_osel <= n_osel; r_oscore <= n_oscore;
        if (w_load) begin
            r_ex[i_ap_index]   <= i_pos_x;
            r_ey[i_ap_index]   <= i_pos_y;
            r_eu[i_ap_index]   <= i_connected_users;
            r_el[i_ap_index]   <= i_channel_load;
            r_rcnt[i_ap_index] <= '0;
            r_rsum[i_ap_index] <= '0;
        end
        if (w_rate) begin
            r_rsum[rd] <= rsum_new;
            r_rcnt[rd] <= r_rcnt[rd] + 8'd1;
        end
        if (w_p1) begin
            if (r_state == S_CMP) begin
                r_cand[rd] <= (r_d2 <= {1'b0, r_thr2});
            end else begin
                r_tput[rd] <= r_cur_t;
                r_dist[rd] <= r_cur_d;
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_found       = r_ofound;
    assign o_selected_ap = r_osel;
    assign o_best_score  = r_oscore;

    a_no_find_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_selected_ap == '0 && o_best_score == '0)
        else $error("empty selection carries nonzero payload");

    a_div_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_ADDW || r_state == S_RECIP || r_state == S_TPUT ||
                     r_state == S_STW || r_state == S_SDW || r_state == S_SUW)
        else $error("divider finished outside a wait state");

    a_fin_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> r_i >= r_n || !r_found)
        else $error("select finished before the table scan");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside the final step");

endmodule
